// File: hw/rtl/ftm_pkg.sv
// shared constants and helpers for the fibonacci term modulo power-of-ten block
package ftm_pkg;

  localparam int unsigned TERM_W  = 16;
  localparam int unsigned DIGIT_W = 3;
  localparam int unsigned OUT_W   = 14;
  localparam int unsigned DCLAMP_W = 4;
  // every modulus 10^d is at least 2^MOD_FLOOR_BITS
  localparam int unsigned MOD_FLOOR_BITS = 3;
  localparam int unsigned POW_W = 30;

  function automatic logic [POW_W-1:0] ftm_pow10(input logic [DCLAMP_W-1:0] digits);
    logic [POW_W-1:0] res;
    case (digits)
      4'd1:    res = POW_W'(10);
      4'd2:    res = POW_W'(100);
      4'd3:    res = POW_W'(1000);
      4'd4:    res = POW_W'(10000);
      4'd5:    res = POW_W'(100000);
      4'd6:    res = POW_W'(1000000);
      4'd7:    res = POW_W'(10000000);
      4'd8:    res = POW_W'(100000000);
      4'd9:    res = POW_W'(1000000000);
      default: res = POW_W'(10);
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/ftm_modmac.sv
// shared unit: (a*b + c*d) mod m with one multiplier and a bit-serial restoring reduction
module ftm_modmac import ftm_pkg::*; #(
  parameter int unsigned VAL_W = 14,
  parameter int unsigned OPW   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OPW-1:0]   a_i,
  input  logic [VAL_W-1:0] b_i,
  input  logic [OPW-1:0]   c_i,
  input  logic [VAL_W-1:0] d_i,
  input  logic [VAL_W-1:0] mod_i,
  output logic             done_o,
  output logic [VAL_W-1:0] rem_o
);

  localparam int unsigned PW    = OPW + VAL_W;
  localparam int unsigned XW    = PW + 1;
  localparam int unsigned SHIFT = XW - MOD_FLOOR_BITS;
  localparam int unsigned MW    = VAL_W + SHIFT;
  localparam int unsigned CNT_W = $clog2(SHIFT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_RED
  } state_e;

  state_e           state_q, state_d;
  logic [MW-1:0]    x_q, x_d;
  logic [MW-1:0]    m_q, m_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [OPW-1:0]   mul_a;
  logic [VAL_W-1:0] mul_b;
  logic [PW-1:0]    prod;

  // operands stay put from start until done, so a then c can share the multiplier
  assign mul_a = (state_q == ST_IDLE) ? a_i : c_i;
  assign mul_b = (state_q == ST_IDLE) ? b_i : d_i;
  assign prod  = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d     = MW'(prod);
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        x_d     = x_q + MW'(prod);
        m_d     = MW'(mod_i) << SHIFT;
        cnt_d   = CNT_W'(SHIFT);
        state_d = ST_RED;
      end
      ST_RED: begin
        if (x_q >= m_q) begin
          x_d = x_q - m_q;
        end
        m_d = m_q >> 1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q     <= '0;
      m_q     <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      m_q     <= m_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = x_q[VAL_W-1:0];

endmodule

// File: hw/rtl/fibonacci_term_mod_power_of_ten.sv
// fibonacci-type term modulo 10^m by 2x2 matrix square-and-multiply on a shared modular unit
// one request at a time; input stalls from accept until the result moves to the output register
// a request uses the shared unit for 1 modular product pair when n = 0, else for
// 3 + 4*popcount(n-1) + 4*bitlen(n-1) product pairs
// reset is asynchronous, active low, and returns the sequencer to idle with no result pending.
module fibonacci_term_mod_power_of_ten import ftm_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 4,
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TERM_W-1:0]     first_term_i,
  input  logic [TERM_W-1:0]     second_term_i,
  input  logic [INDEX_BITS-1:0] term_index_i,
  input  logic [DIGIT_W-1:0]    digit_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_W-1:0]      term_value_o
);

  localparam int unsigned VAL_W = $clog2(10 ** MAX_DIGITS);
  localparam int unsigned OPW   = (VAL_W > TERM_W) ? VAL_W : TERM_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_F0,
    ST_RED_F1,
    ST_LOOP,
    ST_ACC,
    ST_SQR,
    ST_FINAL,
    ST_OUT
  } state_e;

  state_e                     state_q, state_d;
  logic                       issued_q, issued_d;
  logic [1:0]                 idx_q, idx_d;
  logic [TERM_W-1:0]          f0_q, f0_d;
  logic [TERM_W-1:0]          f1_q, f1_d;
  logic [VAL_W-1:0]           f0r_q, f0r_d;
  logic [VAL_W-1:0]           f1r_q, f1r_d;
  logic [INDEX_BITS-1:0]      e_q, e_d;
  logic                       nzero_q, nzero_d;
  logic [VAL_W-1:0]           md_q, md_d;
  logic [3:0][VAL_W-1:0]      acc_q, acc_d;
  logic [3:0][VAL_W-1:0]      base_q, base_d;
  logic [3:0][VAL_W-1:0]      tmp_q, tmp_d;
  logic [VAL_W-1:0]           res_q, res_d;
  logic                       out_valid_q, out_valid_d;
  logic [VAL_W-1:0]           term_q, term_d;

  logic [DCLAMP_W-1:0]        digits;
  logic                       in_fire;
  logic                       unit_start;
  logic                       unit_done;
  logic [VAL_W-1:0]           unit_rem;
  logic [OPW-1:0]             op_a, op_c;
  logic [VAL_W-1:0]           op_b, op_d;
  logic [3:0][VAL_W-1:0]      mx, my;
  logic                       busy_state;

  assign in_fire = in_valid_i && !in_stall_o;

  // out-of-range digit counts saturate
  always_comb begin
    if (digit_count_i == '0) begin
      digits = DCLAMP_W'(1);
    end else if (DCLAMP_W'(digit_count_i) > DCLAMP_W'(MAX_DIGITS)) begin
      digits = DCLAMP_W'(MAX_DIGITS);
    end else begin
      digits = DCLAMP_W'(digit_count_i);
    end
  end

  // entry {i,j} of x*y is x[i][0]*y[0][j] + x[i][1]*y[1][j]
  always_comb begin
    mx = (state_q == ST_SQR) ? base_q : acc_q;
    my = base_q;
    op_a = OPW'(idx_q[1] ? mx[2] : mx[0]);
    op_c = OPW'(idx_q[1] ? mx[3] : mx[1]);
    op_b = idx_q[0] ? my[1] : my[0];
    op_d = idx_q[0] ? my[3] : my[2];
    case (state_q)
      ST_RED_F0: begin
        op_a = OPW'(f0_q);
        op_b = VAL_W'(1);
        op_c = '0;
        op_d = '0;
      end
      ST_RED_F1: begin
        op_a = OPW'(f1_q);
        op_b = VAL_W'(1);
        op_c = '0;
        op_d = '0;
      end
      ST_FINAL: begin
        op_a = OPW'(f1r_q);
        op_b = acc_q[0];
        op_c = OPW'(f0r_q);
        op_d = acc_q[1];
      end
      default: ;
    endcase
  end

  assign busy_state = (state_q == ST_RED_F0) || (state_q == ST_RED_F1) ||
                      (state_q == ST_ACC) || (state_q == ST_SQR) || (state_q == ST_FINAL);
  assign unit_start = busy_state && !issued_q;

  ftm_modmac #(
    .VAL_W (VAL_W),
    .OPW   (OPW)
  ) u_modmac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .c_i     (op_c),
    .d_i     (op_d),
    .mod_i   (md_q),
    .done_o  (unit_done),
    .rem_o   (unit_rem)
  );

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    idx_d       = idx_q;
    f0_d        = f0_q;
    f1_d        = f1_q;
    f0r_d       = f0r_q;
    f1r_d       = f1r_q;
    e_d         = e_q;
    nzero_d     = nzero_q;
    md_d        = md_q;
    acc_d       = acc_q;
    base_d      = base_q;
    tmp_d       = tmp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    term_d      = term_q;

    if (unit_start) begin
      issued_d = 1'b1;
    end
    if (unit_done) begin
      issued_d = 1'b0;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          f0_d    = first_term_i;
          f1_d    = second_term_i;
          e_d     = term_index_i - 1'b1;
          nzero_d = (term_index_i == '0);
          md_d    = VAL_W'(ftm_pow10(digits));
          acc_d   = {VAL_W'(1), VAL_W'(0), VAL_W'(0), VAL_W'(1)};
          base_d  = {VAL_W'(0), VAL_W'(1), VAL_W'(1), VAL_W'(1)};
          state_d = ST_RED_F0;
        end
      end
      ST_RED_F0: begin
        if (unit_done) begin
          f0r_d = unit_rem;
          if (nzero_q) begin
            res_d   = unit_rem;
            state_d = ST_OUT;
          end else begin
            state_d = ST_RED_F1;
          end
        end
      end
      ST_RED_F1: begin
        if (unit_done) begin
          f1r_d   = unit_rem;
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        idx_d = '0;
        if (e_q == '0) begin
          state_d = ST_FINAL;
        end else if (e_q[0]) begin
          state_d = ST_ACC;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_ACC: begin
        if (unit_done) begin
          tmp_d[idx_q] = unit_rem;
          idx_d        = idx_q + 1'b1;
          if (idx_q == 2'd3) begin
            acc_d   = {unit_rem, tmp_q[2], tmp_q[1], tmp_q[0]};
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (unit_done) begin
          tmp_d[idx_q] = unit_rem;
          idx_d        = idx_q + 1'b1;
          if (idx_q == 2'd3) begin
            base_d  = {unit_rem, tmp_q[2], tmp_q[1], tmp_q[0]};
            e_d     = e_q >> 1;
            state_d = ST_LOOP;
          end
        end
      end
      ST_FINAL: begin
        if (unit_done) begin
          res_d   = unit_rem;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hand off once the output register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          term_d      = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      idx_q       <= '0;
      f0_q        <= '0;
      f1_q        <= '0;
      f0r_q       <= '0;
      f1r_q       <= '0;
      e_q         <= '0;
      nzero_q     <= 1'b0;
      md_q        <= '0;
      acc_q       <= '0;
      base_q      <= '0;
      tmp_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      term_q      <= '0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      idx_q       <= idx_d;
      f0_q        <= f0_d;
      f1_q        <= f1_d;
      f0r_q       <= f0r_d;
      f1r_q       <= f1r_d;
      e_q         <= e_d;
      nzero_q     <= nzero_d;
      md_q        <= md_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      tmp_q       <= tmp_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      term_q      <= term_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign term_value_o = OUT_W'(term_q);

endmodule
